[src/ctok_pkg.sv]
// Package for the source tokenizer: lexer mode and action codes,
// character constants and the separator class function.
// No dependencies.
package ctok_pkg;

    // Most actions one source byte can cause
    localparam int RES_MAX = 4;
    localparam int RES_IDX_W = $clog2(RES_MAX);
    localparam int RES_CNT_W = $clog2(RES_MAX + 1);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STRING = 3'd4,
        MODE_ESC    = 3'd5
    } t_lex_mode;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_CLOSE  = 2'd1,
        ACT_EMIT   = 2'd2
    } t_action;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Whitespace, NUL, punctuation and operator bytes split tokens
    function automatic logic is_sep(input logic [7:0] c);
        logic hit;
        begin
            case (c)
                CH_SPACE, CH_LF, CH_TAB, CH_CR, CH_NUL,
                CH_DOT, CH_LT, CH_GT, CH_COMMA, CH_SEMI,
                CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_PCT: hit = 1'b1;
                default: hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

endpackage

[src/ctok_if.sv]
// Valid/ready channel interfaces for the source tokenizer.
// Depends on nothing but the beat fields.
interface ctok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       final_byte;

    modport source (output valid, output src_byte, output final_byte, input ready);
    modport sink   (input valid, input src_byte, input final_byte, output ready);
endinterface

interface ctok_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] token_char;
    logic       run_end;

    modport source (output valid, output action, output token_char, output run_end,
                    input ready);
    modport sink   (input valid, input action, input token_char, input run_end,
                    output ready);
endinterface

[src/c_like_source_tokenizer_unit.sv]
// Source tokenizer: one source byte in, zero to four token actions out.
// A byte's first action is valid in the cycle after it is accepted.
// Throughput (output ready): one byte per cycle with at most one action; a
// byte with N actions holds the buffer until all N are taken, one a cycle.
// Reset (i_rst_n low, synchronous): normal mode, no open token, buffer empty.
module c_like_source_tokenizer_unit
    import ctok_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctok_in_if.sink     i_in,
    ctok_out_if.source  o_out
);

    // Lexer state
    t_lex_mode r_mode;
    logic      r_star;
    logic      r_token_open;

    // Result buffer for one byte's actions
    t_action               r_act [RES_MAX];
    logic [7:0]            r_chr [RES_MAX];
    logic [RES_CNT_W-1:0]  r_cnt;
    logic [RES_IDX_W-1:0]  r_idx;

    t_lex_mode             n_mode;
    logic                  n_star;
    logic                  n_token_open;
    t_action               n_act [RES_MAX];
    logic [7:0]            n_chr [RES_MAX];
    logic [RES_CNT_W-1:0]  n_cnt;

    logic in_fire;
    logic out_fire;
    logic last_beat;

    // Work out all actions of the incoming byte and the next lexer state
    always_comb begin
        logic [7:0] c;
        logic       fin;
        logic       do_norm;
        c       = i_in.src_byte;
        fin     = i_in.final_byte;
        do_norm = 1'b0;
        n_mode       = r_mode;
        n_star       = r_star;
        n_token_open = r_token_open;
        n_cnt        = '0;
        for (int k = 0; k < RES_MAX; k++) begin
            n_act[k] = ACT_CLOSE;
            n_chr[k] = CH_NUL;
        end

        case (r_mode)
            MODE_SLASH: begin
                n_mode = MODE_NORMAL;
                if (c == CH_SLASH || c == CH_STAR) begin
                    n_act[n_cnt[RES_IDX_W-1:0]] = ACT_APPEND;
                    n_chr[n_cnt[RES_IDX_W-1:0]] = CH_SLASH;
                    n_cnt = n_cnt + 1'b1;
                    n_act[n_cnt[RES_IDX_W-1:0]] = ACT_APPEND;
                    n_chr[n_cnt[RES_IDX_W-1:0]] = c;
                    n_cnt = n_cnt + 1'b1;
                    n_token_open = 1'b1;
                    if (c == CH_SLASH) begin
                        n_mode = MODE_LINE;
                    end else begin
                        n_mode = MODE_BLOCK;
                        n_star = 1'b0;
                    end
                end else begin
                    n_act[n_cnt[RES_IDX_W-1:0]] = ACT_EMIT;
                    n_chr[n_cnt[RES_IDX_W-1:0]] = CH_SLASH;
                    n_cnt = n_cnt + 1'b1;
                    do_norm = 1'b1;
                end
            end
            MODE_LINE: begin
                if (c == CH_LF || c == CH_CR || c == CH_NUL) begin
                    if (n_token_open) begin
                        n_act[n_cnt[RES_IDX_W-1:0]] = ACT_CLOSE;
                        n_chr[n_cnt[RES_IDX_W-1:0]] = CH_NUL;
                        n_cnt = n_cnt + 1'b1;
                        n_token_open = 1'b0;
                    end
                    if (c != CH_NUL) begin
                        n_act[n_cnt[RES_IDX_W-1:0]] = ACT_EMIT;
                        n_chr[n_cnt[RES_IDX_W-1:0]] = c;
                        n_cnt = n_cnt + 1'b1;
                    end
                    n_mode = MODE_NORMAL;
                end else begin
                    n_act[n_cnt[RES_IDX_W-1:0]] = ACT_APPEND;
                    n_chr[n_cnt[RES_IDX_W-1:0]] = c;
                    n_cnt = n_cnt + 1'b1;
                    n_token_open = 1'b1;
                end
            end
            MODE_BLOCK: begin
                n_act[n_cnt[RES_IDX_W-1:0]] = ACT_APPEND;
                n_chr[n_cnt[RES_IDX_W-1:0]] = c;
                n_cnt = n_cnt + 1'b1;
                n_token_open = 1'b1;
                if (r_star && c == CH_SLASH) begin
                    n_mode = MODE_NORMAL;
                    n_star = 1'b0;
                end else begin
                    n_star = (c == CH_STAR);
                end
            end
            MODE_STRING: begin
                n_act[n_cnt[RES_IDX_W-1:0]] = ACT_APPEND;
                n_chr[n_cnt[RES_IDX_W-1:0]] = c;
                n_cnt = n_cnt + 1'b1;
                n_token_open = 1'b1;
                if (c == CH_BSLASH) begin
                    n_mode = MODE_ESC;
                end else if (c == CH_QUOTE) begin
                    n_act[n_cnt[RES_IDX_W-1:0]] = ACT_CLOSE;
                    n_chr[n_cnt[RES_IDX_W-1:0]] = CH_NUL;
                    n_cnt = n_cnt + 1'b1;
                    n_token_open = 1'b0;
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_ESC: begin
                n_act[n_cnt[RES_IDX_W-1:0]] = ACT_APPEND;
                n_chr[n_cnt[RES_IDX_W-1:0]] = c;
                n_cnt = n_cnt + 1'b1;
                n_token_open = 1'b1;
                n_mode = MODE_STRING;
            end
            default: begin
                n_mode = MODE_NORMAL;
                do_norm = 1'b1;
            end
        endcase

        // Ordinary handling of a byte outside comments and strings
        if (do_norm) begin
            if (is_sep(c)) begin
                if (n_token_open) begin
                    n_act[n_cnt[RES_IDX_W-1:0]] = ACT_CLOSE;
                    n_chr[n_cnt[RES_IDX_W-1:0]] = CH_NUL;
                    n_cnt = n_cnt + 1'b1;
                    n_token_open = 1'b0;
                end
                if (c != CH_NUL) begin
                    n_act[n_cnt[RES_IDX_W-1:0]] = ACT_EMIT;
                    n_chr[n_cnt[RES_IDX_W-1:0]] = c;
                    n_cnt = n_cnt + 1'b1;
                end
            end else if (c == CH_SLASH) begin
                if (n_token_open) begin
                    n_act[n_cnt[RES_IDX_W-1:0]] = ACT_CLOSE;
                    n_chr[n_cnt[RES_IDX_W-1:0]] = CH_NUL;
                    n_cnt = n_cnt + 1'b1;
                    n_token_open = 1'b0;
                end
                if (fin) begin
                    n_act[n_cnt[RES_IDX_W-1:0]] = ACT_EMIT;
                    n_chr[n_cnt[RES_IDX_W-1:0]] = CH_SLASH;
                    n_cnt = n_cnt + 1'b1;
                end else begin
                    n_mode = MODE_SLASH;
                end
            end else if (c == CH_QUOTE) begin
                if (n_token_open) begin
                    n_act[n_cnt[RES_IDX_W-1:0]] = ACT_CLOSE;
                    n_chr[n_cnt[RES_IDX_W-1:0]] = CH_NUL;
                    n_cnt = n_cnt + 1'b1;
                end
                n_act[n_cnt[RES_IDX_W-1:0]] = ACT_APPEND;
                n_chr[n_cnt[RES_IDX_W-1:0]] = c;
                n_cnt = n_cnt + 1'b1;
                n_token_open = 1'b1;
                if (!fin) begin
                    n_mode = MODE_STRING;
                end
            end else begin
                n_act[n_cnt[RES_IDX_W-1:0]] = ACT_APPEND;
                n_chr[n_cnt[RES_IDX_W-1:0]] = c;
                n_cnt = n_cnt + 1'b1;
                n_token_open = 1'b1;
                if (fin) begin
                    n_act[n_cnt[RES_IDX_W-1:0]] = ACT_CLOSE;
                    n_chr[n_cnt[RES_IDX_W-1:0]] = CH_NUL;
                    n_cnt = n_cnt + 1'b1;
                    n_token_open = 1'b0;
                    n_act[n_cnt[RES_IDX_W-1:0]] = ACT_EMIT;
                    n_chr[n_cnt[RES_IDX_W-1:0]] = CH_SPACE;
                    n_cnt = n_cnt + 1'b1;
                end
            end
        end

        // End of input: close what is open and drop back to normal
        if (fin) begin
            if (n_token_open) begin
                n_act[n_cnt[RES_IDX_W-1:0]] = ACT_CLOSE;
                n_chr[n_cnt[RES_IDX_W-1:0]] = CH_NUL;
                n_cnt = n_cnt + 1'b1;
                n_token_open = 1'b0;
            end
            n_mode = MODE_NORMAL;
            n_star = 1'b0;
        end
    end

    // Handshake: take a new byte once the buffer drains its last beat
    assign out_fire  = o_out.valid && o_out.ready;
    assign last_beat = (r_idx == RES_IDX_W'(r_cnt - 1'b1));
    assign in_fire   = i_in.valid && i_in.ready;

    assign i_in.ready       = (r_cnt == '0) || (out_fire && last_beat);
    assign o_out.valid      = (r_cnt != '0);
    assign o_out.action     = r_act[r_idx];
    assign o_out.token_char = r_chr[r_idx];
    assign o_out.run_end    = last_beat;

    // Advance lexer state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_star       <= 1'b0;
            r_token_open <= 1'b0;
        end else if (in_fire) begin
            r_mode       <= n_mode;
            r_star       <= n_star;
            r_token_open <= n_token_open;
        end
    end

    // Load the result buffer and step through it beat by beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (in_fire) begin
            r_cnt <= n_cnt;
            r_idx <= '0;
        end else if (out_fire && last_beat) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (out_fire) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < RES_MAX; k++) begin
                r_act[k] <= n_act[k];
                r_chr[k] <= n_chr[k];
            end
        end
    end

    // Read index stays inside the loaded actions
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ({1'b0, r_idx} < r_cnt))
        else $error("result index past action count");

    // Buffer never holds more than the per-byte maximum
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RES_CNT_W'(RES_MAX))
        else $error("action count over maximum");

    // A final byte leaves the lexer in normal mode with nothing open
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.final_byte) |=> (r_mode == MODE_NORMAL && !r_token_open && !r_star))
        else $error("state not cleared after final byte");

    // A fresh byte starts its actions at the first buffer entry
    a_load_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_idx == '0))
        else $error("result index not rewound on load");

endmodule

[tb/sv/tb_c_like_source_tokenizer_unit.sv]
// Self-checking testbench for c_like_source_tokenizer_unit: feeds source bytes, predicts
// the token actions of each byte and checks every action beat against the prediction.
// Depends on ctok_pkg, ctok_in_if / ctok_out_if and the tokenizer top level.
`timescale 1ns / 1ps

module tb_c_like_source_tokenizer_unit;
    import ctok_pkg::*;

    localparam int RANDOM_ITEMS = 256;
    localparam int TAIL_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [7:0] b;
        logic       fin;
    } t_src_item;

    typedef struct packed {
        t_action    act;
        logic [7:0] ch;
        logic       last;
    } t_tok_act;

    logic i_clk;
    logic i_rst_n;

    ctok_in_if  byte_ch ();
    ctok_out_if act_ch ();

    c_like_source_tokenizer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch.sink),
        .o_out   (act_ch.source)
    );

    logic [7:0] sep_chars [0:18] = '{
        CH_SPACE, CH_LF, CH_TAB, CH_CR, CH_NUL, CH_DOT, CH_LT, CH_GT, CH_COMMA, CH_SEMI,
        CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_PCT
    };

    t_src_item pend_bytes [$];
    t_tok_act  token_actions_due [$];
    t_tok_act  step_acts [$];

    // Predicted lexer state
    t_lex_mode pred_mode;
    logic      pred_star;
    logic      pred_open;

    int        error_count = 0;
    int        cycle_count = 0;
    int        src_gap = 0;
    int        sink_stall = 0;
    int        src_idle_pct = 0;
    int        sink_idle_pct = 0;
    int        bytes_taken = 0;
    int        acts_taken = 0;
    t_src_item next_item;
    t_tok_act  got_act;
    t_tok_act  want_act;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Token action predictor
    // ------------------------------------------------------------------
    function automatic logic splits_token(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        foreach (sep_chars[k])
            if (sep_chars[k] == c) hit = 1'b1;
        return hit;
    endfunction

    task automatic put_act(input t_action a, input logic [7:0] ch);
        step_acts.push_back('{a, ch, 1'b0});
    endtask

    task automatic close_token();
        if (pred_open) begin
            put_act(ACT_CLOSE, CH_NUL);
            pred_open = 1'b0;
        end
    endtask

    task automatic append_char(input logic [7:0] c);
        put_act(ACT_APPEND, c);
        pred_open = 1'b1;
    endtask

    // Byte seen in normal mode
    task automatic plain_byte(input logic [7:0] c, input logic fin);
        if (splits_token(c)) begin
            close_token();
            if (c != CH_NUL) put_act(ACT_EMIT, c);
        end else if (c == CH_SLASH) begin
            close_token();
            if (fin) put_act(ACT_EMIT, CH_SLASH);
            else pred_mode = MODE_SLASH;
        end else if (c == CH_QUOTE) begin
            close_token();
            append_char(c);
            if (fin) close_token();
            else pred_mode = MODE_STRING;
        end else begin
            append_char(c);
            if (fin) begin
                close_token();
                put_act(ACT_EMIT, CH_SPACE);
            end
        end
    endtask

    task automatic predict_token_actions(input logic [7:0] c, input logic fin);
        step_acts.delete();
        case (pred_mode)
            MODE_SLASH: begin
                pred_mode = MODE_NORMAL;
                if (c == CH_SLASH) begin
                    append_char(CH_SLASH);
                    append_char(CH_SLASH);
                    pred_mode = MODE_LINE;
                end else if (c == CH_STAR) begin
                    append_char(CH_SLASH);
                    append_char(CH_STAR);
                    pred_mode = MODE_BLOCK;
                    pred_star = 1'b0;
                end else begin
                    put_act(ACT_EMIT, CH_SLASH);
                    plain_byte(c, fin);
                end
            end
            MODE_LINE: begin
                if (c == CH_LF || c == CH_CR || c == CH_NUL) begin
                    close_token();
                    if (c != CH_NUL) put_act(ACT_EMIT, c);
                    pred_mode = MODE_NORMAL;
                end else begin
                    append_char(c);
                end
            end
            MODE_BLOCK: begin
                append_char(c);
                if (pred_star && c == CH_SLASH) begin
                    pred_mode = MODE_NORMAL;
                    pred_star = 1'b0;
                end else begin
                    pred_star = (c == CH_STAR);
                end
            end
            MODE_STRING: begin
                append_char(c);
                if (c == CH_BSLASH) begin
                    pred_mode = MODE_ESC;
                end else if (c == CH_QUOTE) begin
                    close_token();
                    pred_mode = MODE_NORMAL;
                end
            end
            MODE_ESC: begin
                append_char(c);
                pred_mode = MODE_STRING;
            end
            default: begin
                pred_mode = MODE_NORMAL;
                plain_byte(c, fin);
            end
        endcase
        // End of input flushes everything
        if (fin) begin
            close_token();
            pred_mode = MODE_NORMAL;
            pred_star = 1'b0;
        end
        if (step_acts.size() > 0) step_acts[step_acts.size() - 1].last = 1'b1;
        foreach (step_acts[k]) token_actions_due.push_back(step_acts[k]);
    endtask

    // ------------------------------------------------------------------
    // Byte driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            // Predict on every accepted beat
            if (byte_ch.valid && byte_ch.ready) begin
                predict_token_actions(byte_ch.src_byte, byte_ch.final_byte);
                bytes_taken++;
                if (bytes_taken % 32 == 0) begin
                    case ($urandom_range(0, 2))
                        0: src_idle_pct = 0;
                        1: src_idle_pct = 15;
                        default: src_idle_pct = 40;
                    endcase
                end
            end
            // Advance to the next beat once the slot is free
            if (!byte_ch.valid || byte_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    byte_ch.valid <= 1'b0;
                end else if (pend_bytes.size() > 0) begin
                    next_item = pend_bytes.pop_front();
                    byte_ch.valid      <= 1'b1;
                    byte_ch.src_byte   <= next_item.b;
                    byte_ch.final_byte <= next_item.fin;
                    if (pend_bytes.size() >= TAIL_ITEMS &&
                        $urandom_range(0, 99) < src_idle_pct)
                        src_gap = $urandom_range(1, 11);
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Action monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            act_ch.ready <= 1'b0;
        end else begin
            // Compare each accepted beat with the oldest prediction
            if (act_ch.valid && act_ch.ready) begin
                got_act.act  = t_action'(act_ch.action);
                got_act.ch   = act_ch.token_char;
                got_act.last = act_ch.run_end;
                if (token_actions_due.size() == 0) begin
                    $display("%0t: unexpected action beat, got action %0d char %h run_end %b",
                             $time, got_act.act, got_act.ch, got_act.last);
                    error_count++;
                end else begin
                    want_act = token_actions_due.pop_front();
                    if (got_act.act !== want_act.act) begin
                        $display("%0t: action mismatch, expected %0d, got %0d",
                                 $time, want_act.act, got_act.act);
                        error_count++;
                    end
                    if (got_act.ch !== want_act.ch) begin
                        $display("%0t: token_char mismatch, expected %h, got %h",
                                 $time, want_act.ch, got_act.ch);
                        error_count++;
                    end
                    if (got_act.last !== want_act.last) begin
                        $display("%0t: run_end mismatch, expected %b, got %b",
                                 $time, want_act.last, got_act.last);
                        error_count++;
                    end
                end
                acts_taken++;
                if (acts_taken % 24 == 0) begin
                    case ($urandom_range(0, 2))
                        0: sink_idle_pct = 0;
                        1: sink_idle_pct = 10;
                        default: sink_idle_pct = 35;
                    endcase
                end
            end
            // Hold off the output side in bursts
            if (sink_stall > 0) begin
                sink_stall--;
                act_ch.ready <= 1'b0;
            end else begin
                act_ch.ready <= 1'b1;
                if (pend_bytes.size() >= TAIL_ITEMS && $urandom_range(0, 99) < sink_idle_pct)
                    sink_stall = $urandom_range(1, 11);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic fin);
        pend_bytes.push_back('{b, fin});
    endtask

    initial begin : main
        int         kind;
        int         len;
        int         start_size;
        logic [7:0] b;
        logic       cut;

        byte_ch.valid      = 1'b0;
        byte_ch.src_byte   = 8'h00;
        byte_ch.final_byte = 1'b0;
        act_ch.ready       = 1'b0;
        i_rst_n            = 1'b0;
        pred_mode          = MODE_NORMAL;
        pred_star          = 1'b0;
        pred_open          = 1'b0;

        // Directed: ordinary token closed by a space
        push_byte("a", 1'b0);
        push_byte(CH_SPACE, 1'b0);
        // NUL closing a token, then NUL with nothing open
        push_byte("x", 1'b0);
        push_byte(CH_NUL, 1'b0);
        push_byte(CH_NUL, 1'b0);
        // Lone slash
        push_byte(CH_SLASH, 1'b0);
        push_byte("q", 1'b0);
        // Line comment ended by CR
        push_byte(CH_SLASH, 1'b0);
        push_byte(CH_SLASH, 1'b0);
        push_byte("z", 1'b0);
        push_byte(CH_CR, 1'b0);
        // Block comment whose token stays open after the close
        push_byte(CH_SLASH, 1'b0);
        push_byte(CH_STAR, 1'b0);
        push_byte(CH_STAR, 1'b0);
        push_byte(CH_SLASH, 1'b0);
        push_byte("m", 1'b0);
        push_byte(CH_SEMI, 1'b0);
        // String with an escaped quote
        push_byte(CH_QUOTE, 1'b0);
        push_byte(CH_BSLASH, 1'b0);
        push_byte(CH_QUOTE, 1'b0);
        push_byte(CH_QUOTE, 1'b0);
        // Final byte: ordinary top value, slash, quote
        push_byte(8'hFF, 1'b1);
        push_byte(CH_SLASH, 1'b1);
        push_byte(CH_QUOTE, 1'b1);

        // Random: mostly well-formed constructs with random content
        start_size = pend_bytes.size();
        while (pend_bytes.size() < start_size + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            cut  = ($urandom_range(0, 7) == 0);
            case (kind)
                0, 1, 2: begin
                    len = $urandom_range(1, 6);
                    repeat (len) begin
                        b = 8'($urandom_range(0, 255));
                        if (splits_token(b) || b == CH_SLASH || b == CH_QUOTE)
                            b = 8'($urandom_range("a", "z"));
                        push_byte(b, 1'b0);
                    end
                end
                3: push_byte(sep_chars[$urandom_range(0, 18)], 1'b0);
                4: begin
                    push_byte(CH_SLASH, 1'b0);
                    push_byte(CH_SLASH, 1'b0);
                    len = $urandom_range(0, 6);
                    repeat (len) push_byte(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
                    if (cut) begin
                        pend_bytes[pend_bytes.size() - 1].fin = 1'b1;
                    end else begin
                        case ($urandom_range(0, 2))
                            0: push_byte(CH_LF, 1'b0);
                            1: push_byte(CH_CR, 1'b0);
                            default: push_byte(CH_NUL, 1'b0);
                        endcase
                    end
                end
                5: begin
                    push_byte(CH_SLASH, 1'b0);
                    push_byte(CH_STAR, 1'b0);
                    len = $urandom_range(0, 6);
                    repeat (len) begin
                        case ($urandom_range(0, 3))
                            0: push_byte(CH_STAR, 1'b0);
                            1: push_byte(CH_SLASH, 1'b0);
                            2: push_byte(CH_LF, 1'b0);
                            default: push_byte(8'($urandom_range(0, 255)), 1'b0);
                        endcase
                    end
                    if (cut) begin
                        pend_bytes[pend_bytes.size() - 1].fin = 1'b1;
                    end else begin
                        push_byte(CH_STAR, 1'b0);
                        push_byte(CH_SLASH, 1'b0);
                        // An optional byte joins the still open comment token, then a separator
                        if ($urandom_range(0, 1))
                            push_byte(8'($urandom_range("a", "z")), 1'b0);
                        push_byte(sep_chars[$urandom_range(0, 18)], 1'b0);
                    end
                end
                6: begin
                    push_byte(CH_QUOTE, 1'b0);
                    len = $urandom_range(0, 6);
                    repeat (len) begin
                        if ($urandom_range(0, 4) == 0) begin
                            push_byte(CH_BSLASH, 1'b0);
                            push_byte(8'($urandom_range(0, 255)), 1'b0);
                        end else begin
                            push_byte(8'($urandom_range("a", "z")), 1'b0);
                        end
                    end
                    if (cut) pend_bytes[pend_bytes.size() - 1].fin = 1'b1;
                    else push_byte(CH_QUOTE, 1'b0);
                end
                7: begin
                    push_byte(CH_SLASH, 1'b0);
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
                8: push_byte(8'($urandom_range(0, 255)), 1'b0);
                default: begin
                    if ($urandom_range(0, 1)) push_byte(8'($urandom_range(0, 255)), 1'b1);
                    else pend_bytes[pend_bytes.size() - 1].fin = 1'b1;
                end
            endcase
        end

        // Release reset
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all bytes taken and every predicted action seen
        while (pend_bytes.size() > 0 || byte_ch.valid || token_actions_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && token_actions_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
